FILE: rtl/dltq_pkg.sv
// Shared types, codes and constants of the delta-list timer queue.
package dltq_pkg;

   localparam int DefMaxTasks = 16;
   localparam int MaxResults  = 16;
   localparam int DeltaW      = 13;
   localparam int MsW         = 16;
   localparam int TagW        = 8;
   localparam int SlotOutW    = 4;
   // ms to 10 ms ticks: floor(x / 10) == (x * 52429) >> 19 for any 16-bit x
   localparam logic [16:0] TickRecip = 17'd52429;
   localparam int          TickShift = 19;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_TICK = 2'd1,
      CMD_DISP = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ADD_OK   = 2'd0,
      KIND_ADD_FULL = 2'd1,
      KIND_DUE      = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_TICK,
      OP_CLAIM,
      OP_REJECT,
      OP_LSTART,
      OP_WALK,
      OP_FIN,
      OP_CSTART,
      OP_COUNT,
      OP_POP
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_ADD,
      ST_LSTART,
      ST_WALK,
      ST_FIN,
      ST_CSTART,
      ST_COUNT,
      ST_POP
   } state_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic [1:0] req_cmd;
      logic       out_free;
      logic       free_found;
      logic       nonempty;
      logic       walk_stop;
      logic       count_stop;
      logic       cnt_zero;
      logic       cnt_one;
      logic       period_nz;
   } stat_type;

   // ms value to ticks through the reciprocal product
   function automatic logic [DeltaW-1:0] ms_to_ticks(input logic [MsW-1:0] ms);
      logic [32:0] prod;
      prod = {17'd0, ms} * {16'd0, TickRecip};
      return prod[TickShift+DeltaW-1:TickShift];
   endfunction

endpackage

FILE: rtl/dltq_if.sv
// Request and response channel interfaces.
interface dltq_req_if import dltq_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [1:0]     command;
   logic [TagW-1:0] task_tag;
   logic [MsW-1:0] delay_ms;
   logic [MsW-1:0] period_ms;
   modport source (output valid, command, task_tag, delay_ms, period_ms, input ready);
   modport sink   (input valid, command, task_tag, delay_ms, period_ms, output ready);
endinterface

interface dltq_rsp_if import dltq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [TagW-1:0]    due_tag;
   logic [SlotOutW-1:0] slot_index;
   logic               is_periodic;
   logic               last_result;
   modport source (output valid, kind, due_tag, slot_index, is_periodic, last_result,
                   input ready);
   modport sink   (input valid, kind, due_tag, slot_index, is_periodic, last_result,
                   output ready);
endinterface

FILE: rtl/dltq_datapath.sv
// Slot stores, list pointers, walk registers and result register.
module dltq_datapath import dltq_pkg::*; #(
   parameter int MAX_TASKS = DefMaxTasks
) (
   input  logic         clock,
   input  logic         reset,
   dltq_req_if.sink     req_bus,
   dltq_rsp_if.source   rsp_bus,
   input  ctl_type      ctl,
   output stat_type     stat
);
   localparam int SW      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int DueMax  = (MAX_TASKS < MaxResults) ? MAX_TASKS : MaxResults;
   localparam int CW      = $clog2(DueMax + 1);

   logic [DeltaW-1:0] delta_mem  [MAX_TASKS];
   logic [MsW-1:0]    period_mem [MAX_TASKS];
   logic [TagW-1:0]   tag_mem    [MAX_TASKS];
   logic [SW-1:0]     next_mem   [MAX_TASKS];
   logic              lv_mem     [MAX_TASKS];
   logic [MAX_TASKS-1:0] busy_ff;

   logic [SW-1:0]     head_ff, cur_ff, prev_ff, slot_ff;
   logic              nonempty_ff, hp_ff, hc_ff;
   logic [DeltaW-1:0] ticks_ff;
   logic [CW-1:0]     cnt_ff;
   logic [TagW-1:0]   tag_ff;
   logic [MsW-1:0]    delay_ff, period_ff;

   logic              out_valid_ff;
   kind_type          out_kind_ff;
   logic [TagW-1:0]   out_tag_ff;
   logic [SlotOutW-1:0] out_slot_ff;
   logic              out_per_ff, out_last_ff;

   logic [SW-1:0]     free_idx;
   logic              free_found;
   logic [DeltaW-1:0] cur_delta;
   logic              ge, cur_dz;
   logic [MsW-1:0]    head_period;

   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx   = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign cur_delta   = delta_mem[cur_ff];
   assign ge          = ticks_ff >= cur_delta;
   assign cur_dz      = cur_delta == '0;
   assign head_period = period_mem[head_ff];

   assign stat.req_cmd    = req_bus.command;
   assign stat.out_free   = !out_valid_ff || rsp_bus.ready;
   assign stat.free_found = free_found;
   assign stat.nonempty   = nonempty_ff;
   assign stat.walk_stop  = !ge || !lv_mem[cur_ff];
   assign stat.count_stop = (cnt_ff == CW'(DueMax)) || !cur_dz || !lv_mem[cur_ff];
   assign stat.cnt_zero   = cnt_ff == '0;
   assign stat.cnt_one    = cnt_ff == CW'(1);
   assign stat.period_nz  = head_period != '0;

   // undefined-until-written stores
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_TICK: begin
            if (nonempty_ff && delta_mem[head_ff] != '0)
               delta_mem[head_ff] <= delta_mem[head_ff] - DeltaW'(1);
         end
         OP_CLAIM: begin
            tag_mem[free_idx]    <= tag_ff;
            period_mem[free_idx] <= period_ff;
         end
         OP_LSTART: begin
            if (!nonempty_ff) begin
               delta_mem[slot_ff] <= ticks_ff;
               lv_mem[slot_ff]    <= 1'b0;
            end
         end
         OP_FIN: begin
            delta_mem[slot_ff] <= ticks_ff;
            if (hc_ff) begin
               next_mem[slot_ff]  <= cur_ff;
               lv_mem[slot_ff]    <= 1'b1;
               delta_mem[cur_ff]  <= cur_delta - ticks_ff;
            end else begin
               lv_mem[slot_ff] <= 1'b0;
            end
            if (hp_ff) begin
               next_mem[prev_ff] <= slot_ff;
               lv_mem[prev_ff]   <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         case (ctl.op)
            OP_LATCH: begin
               tag_ff    <= req_bus.task_tag;
               delay_ff  <= req_bus.delay_ms;
               period_ff <= req_bus.period_ms;
            end
            OP_CLAIM: begin
               busy_ff[free_idx] <= 1'b1;
               slot_ff           <= free_idx;
               ticks_ff          <= ms_to_ticks(delay_ff);
            end
            OP_LSTART: begin
               if (!nonempty_ff) begin
                  head_ff     <= slot_ff;
                  nonempty_ff <= 1'b1;
               end else begin
                  cur_ff <= head_ff;
                  hp_ff  <= 1'b0;
               end
            end
            OP_WALK: begin
               hc_ff <= !ge;
               if (ge) begin
                  ticks_ff <= ticks_ff - cur_delta;
                  prev_ff  <= cur_ff;
                  hp_ff    <= 1'b1;
                  if (lv_mem[cur_ff])
                     cur_ff <= next_mem[cur_ff];
               end
            end
            OP_FIN: begin
               if (!hp_ff)
                  head_ff <= slot_ff;
            end
            OP_CSTART: begin
               cur_ff <= head_ff;
               cnt_ff <= '0;
            end
            OP_COUNT: begin
               if (cnt_ff != CW'(DueMax) && cur_dz) begin
                  cnt_ff <= cnt_ff + CW'(1);
                  cur_ff <= next_mem[cur_ff];
               end
            end
            OP_POP: begin
               cnt_ff <= cnt_ff - CW'(1);
               if (lv_mem[head_ff])
                  head_ff <= next_mem[head_ff];
               else
                  nonempty_ff <= 1'b0;
               if (head_period != '0) begin
                  slot_ff  <= head_ff;
                  ticks_ff <= ms_to_ticks(head_period);
               end else begin
                  busy_ff[head_ff] <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         case (ctl.op)
            OP_CLAIM, OP_REJECT, OP_POP: out_valid_ff <= 1'b1;
            default: if (rsp_bus.ready) out_valid_ff <= 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_CLAIM: begin
            out_kind_ff <= KIND_ADD_OK;
            out_tag_ff  <= tag_ff;
            out_slot_ff <= SlotOutW'(free_idx);
            out_per_ff  <= 1'b0;
            out_last_ff <= 1'b1;
         end
         OP_REJECT: begin
            out_kind_ff <= KIND_ADD_FULL;
            out_tag_ff  <= tag_ff;
            out_slot_ff <= '0;
            out_per_ff  <= 1'b0;
            out_last_ff <= 1'b1;
         end
         OP_POP: begin
            out_kind_ff <= KIND_DUE;
            out_tag_ff  <= tag_mem[head_ff];
            out_slot_ff <= SlotOutW'(head_ff);
            out_per_ff  <= head_period != '0;
            out_last_ff <= cnt_ff == CW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.kind        = out_kind_ff;
   assign rsp_bus.due_tag     = out_tag_ff;
   assign rsp_bus.slot_index  = out_slot_ff;
   assign rsp_bus.is_periodic = out_per_ff;
   assign rsp_bus.last_result = out_last_ff;

   a_head_busy: assert property (@(posedge clock) disable iff (reset)
      nonempty_ff |-> busy_ff[head_ff])
      else $error("list head slot is free");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DueMax))
      else $error("due count above limit");

   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_ADD_FULL |-> out_slot_ff == '0)
      else $error("rejected add carries a slot");

   a_tick_dec: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_TICK && nonempty_ff && delta_mem[head_ff] != '0
      |=> delta_mem[$past(head_ff)] == $past(delta_mem[head_ff]) - DeltaW'(1))
      else $error("tick did not decrement head");

   a_pop_needs_count: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_POP |-> cnt_ff != '0 && nonempty_ff)
      else $error("pop without a due entry");

endmodule

FILE: rtl/dltq_ctrl.sv
// Sequencer for add, tick and dispatch requests.
module dltq_ctrl import dltq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctl_type  ctl
);
   state_type state_ff, state_in;
   logic      disp_ff, disp_in;
   state_type after_link;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         disp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         disp_ff  <= disp_in;
      end
   end

   assign after_link = disp_ff ? ST_POP : ST_IDLE;

   always_comb begin
      state_in  = state_ff;
      disp_in   = disp_ff;
      ctl.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op = OP_LATCH;
               case (stat.req_cmd)
                  CMD_ADD:  state_in = ST_ADD;
                  CMD_TICK: state_in = ST_TICK;
                  CMD_DISP: state_in = ST_CSTART;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            ctl.op   = OP_TICK;
            state_in = ST_IDLE;
         end
         ST_ADD: begin
            if (stat.out_free) begin
               if (stat.free_found) begin
                  ctl.op   = OP_CLAIM;
                  disp_in  = 1'b0;
                  state_in = ST_LSTART;
               end else begin
                  ctl.op   = OP_REJECT;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LSTART: begin
            ctl.op   = OP_LSTART;
            state_in = stat.nonempty ? ST_WALK : after_link;
         end
         ST_WALK: begin
            ctl.op = OP_WALK;
            if (stat.walk_stop) state_in = ST_FIN;
         end
         ST_FIN: begin
            ctl.op   = OP_FIN;
            state_in = after_link;
         end
         ST_CSTART: begin
            ctl.op   = OP_CSTART;
            state_in = stat.nonempty ? ST_COUNT : ST_IDLE;
         end
         ST_COUNT: begin
            ctl.op = OP_COUNT;
            if (stat.count_stop) state_in = ST_POP;
         end
         ST_POP: begin
            if (stat.cnt_zero) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               ctl.op = OP_POP;
               if (stat.period_nz) begin
                  disp_in  = 1'b1;
                  state_in = ST_LSTART;
               end else if (stat.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");

   a_walk_after_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> $past(state_ff) == ST_LSTART || $past(state_ff) == ST_WALK)
      else $error("walk entered without list start");

   a_fin_follows_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> $past(state_ff) == ST_WALK)
      else $error("link finish without walk");

endmodule

FILE: rtl/delta_list_task_timer_queue_top.sv
// Top level of the delta-list task timer queue.
// Keeps up to MAX_TASKS timed tasks in one linked list sorted by due time, each
// entry holding its delay in 10 ms ticks relative to the entry ahead of it. One
// request is worked on at a time; a new request is taken once the sequencer is
// back in idle, even while the last response still waits in the output register.
// Tick decrements the head delay unless it is already zero. Add rejects when
// the queue is full, else claims a free slot and links it in: directly into an
// empty list, else after a walk that compares one entry per step. Dispatch does
// nothing on an empty list, else counts the entries inspected (the due run,
// plus the first entry not yet due if there is one), then pops each due entry;
// a periodic entry is relinked, directly into an empty list or else by a walk,
// before the next pop. A closing step in the pop state finishes a dispatch that
// ends on a relink or finds nothing due. A stalled response holds the add and
// pop steps. The list walk steps over the link store one entry per cycle. No
// clearing pass is needed after reset.
module delta_list_task_timer_queue_top import dltq_pkg::*; #(
   parameter int MAX_TASKS = DefMaxTasks
) (
   input  logic       clock,
   input  logic       reset,
   dltq_req_if.sink   req_bus,
   dltq_rsp_if.source rsp_bus
);
   ctl_type  ctl;
   stat_type stat;

   // sequencer: decodes the request and steps the list operations
   dltq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // stores, walk pointers and response register
   dltq_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .ctl     (ctl),
      .stat    (stat)
   );

endmodule
